// ===== rtl/hct_pkg.sv =====
// Shared widths, constants and the square-root stage type of the
// helicity cos(theta) pipeline. No dependencies.
`default_nettype none

package hct_pkg;

	// Input momentum width and cosine fraction width
	localparam int MW = 24;
	localparam int F  = 14;

	// Derived widths
	localparam int QW    = MW + 1;          // pair momentum component
	localparam int LW    = MW + 1;          // limb of a split multiplication
	localparam int DLW   = 2 * LW;          // product of two limbs
	localparam int PW    = 2 * LW;          // dot, |P|^2, cross components
	localparam int EEW   = 2 * MW;          // pair energy squared, mass squared
	localparam int QDW   = MW + LW + 1;     // energy times a signed limb
	localparam int PEW   = LW + MW - 1;     // |P|^2 limb times muon energy
	localparam int AW    = 3 * LW;          // numerator, signed
	localparam int CW    = 4 * LW;          // squared cross product
	localparam int SQW   = 6 * LW;          // A^2 and M2*C^2
	localparam int SW    = SQW + 1;         // their sum
	localparam int RW    = SW + 2 * F + 5;  // square-root residual, signed
	localparam int STEPS = F + 1;           // result bits, one per stage
	localparam int COSW  = F + 2;           // signed cosine
	localparam int PRE   = 8;               // stages ahead of the root
	localparam int NS    = PRE + STEPS + 1; // all stages, output included

	localparam logic signed [COSW-1:0] COS_ONE = COSW'(1) << F;

	// One word in the digit recurrence for the rounded cosine magnitude
	typedef struct packed {
		logic [RW-1:0]    res;    // 4^(F+1)*A^2 - u^2*s
		logic [RW-1:0]    vsh;    // u*s, aligned to the current bit
		logic [RW-1:0]    d;      // s, aligned to the current bit
		logic [STEPS-1:0] c;      // result bits so far, MSB first
		logic             invalid;
		logic             szero;
		logic             aneg;
	} hct_root_t;

endpackage

`default_nettype wire

// ===== rtl/dimuon_helicity_cos_theta_top.sv =====
// Helicity-frame cos(theta) of a muon pair: exact integer pipeline.
// Uses hct_pkg and hct_root_step.
//
//  channel | direction | signals
//  --------+-----------+------------------------------------------------
//  in      | input     | in_valid/in_ready, plus_*/minus_* four-momenta
//  out     | output    | out_valid/out_ready, cos_theta, invalid
//
// One pair per cycle is accepted while the output is not stalled; the pipe holds eight arithmetic
// stages, one digit-recurrence stage per cosine bit (15) and the output.
// Each stage moves when it is empty or the stage after it moves, so bubbles
// close up and a stalled output only halts the stages behind it once full.
// Reset clears the valid bits only.
`default_nettype none

module dimuon_helicity_cos_theta_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [hct_pkg::MW-1:0] plus_px,
	input  wire logic signed [hct_pkg::MW-1:0] plus_py,
	input  wire logic signed [hct_pkg::MW-1:0] plus_pz,
	input  wire logic        [hct_pkg::MW-2:0] plus_energy,
	input  wire logic signed [hct_pkg::MW-1:0] minus_px,
	input  wire logic signed [hct_pkg::MW-1:0] minus_py,
	input  wire logic signed [hct_pkg::MW-1:0] minus_pz,
	input  wire logic        [hct_pkg::MW-2:0] minus_energy,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [hct_pkg::COSW-1:0]    cos_theta,
	output logic                               invalid
);

	localparam int MW    = hct_pkg::MW;
	localparam int QW    = hct_pkg::QW;
	localparam int LW    = hct_pkg::LW;
	localparam int DLW   = hct_pkg::DLW;
	localparam int PW    = hct_pkg::PW;
	localparam int EEW   = hct_pkg::EEW;
	localparam int QDW   = hct_pkg::QDW;
	localparam int PEW   = hct_pkg::PEW;
	localparam int AW    = hct_pkg::AW;
	localparam int CW    = hct_pkg::CW;
	localparam int SQW   = hct_pkg::SQW;
	localparam int SW    = hct_pkg::SW;
	localparam int RW    = hct_pkg::RW;
	localparam int F     = hct_pkg::F;
	localparam int STEPS = hct_pkg::STEPS;
	localparam int COSW  = hct_pkg::COSW;
	localparam int PRE   = hct_pkg::PRE;
	localparam int NS    = hct_pkg::NS;

	// Stage control
	logic [NS:1] vld_q;
	logic [NS:1] en;

	// Stage 1: operands and pair sums
	logic signed [MW-1:0] px_s1, py_s1, pz_s1;
	logic        [MW-2:0] e1_s1;
	logic signed [QW-1:0] qx_s1, qy_s1, qz_s1;
	logic        [MW-1:0] qe_s1;
	// Stage 2: first products
	logic signed [PW-1:0]  dx_s2, dy_s2, dz_s2, sx_s2, sy_s2, sz_s2;
	logic signed [PW-1:0]  yz_s2, zy_s2, zx_s2, xz_s2, xy_s2, yx_s2;
	logic        [EEW-1:0] ee_s2;
	logic        [MW-2:0]  e1_s2;
	logic        [MW-1:0]  qe_s2;
	// Stage 3: dot, |P|^2, mass squared, cross product
	logic signed [PW-1:0]  dot_s3;
	logic        [PW-1:0]  p2_s3;
	logic        [EEW-1:0] m2_s3;
	logic                  inv_s3;
	logic signed [PW-1:0]  cr_s3 [3];
	logic        [MW-2:0]  e1_s3;
	logic        [MW-1:0]  qe_s3;
	// Stage 4: limb products
	logic        [MW+LW-1:0] qd0_s4;
	logic signed [QDW-1:0]   qd1_s4;
	logic        [PEW-1:0]   pe0_s4, pe1_s4;
	logic        [DLW-1:0]   xll_s4 [3];
	logic signed [DLW:0]     xlh_s4 [3];
	logic signed [DLW-1:0]   xhh_s4 [3];
	logic        [EEW-1:0]   m2_s4;
	logic                    inv_s4;
	// Stage 5: numerator and squared cross product
	logic signed [AW-1:0]  a_s5;
	logic        [CW-1:0]  c2_s5;
	logic        [EEW-1:0] m2_s5;
	logic                  inv_s5;
	// Stage 6: limb products of A^2 and M2*C^2
	logic        [DLW-1:0] aa00_s6, aa01_s6, aa11_s6;
	logic signed [DLW:0]   aa02_s6, aa12_s6;
	logic signed [DLW-1:0] aa22_s6;
	logic        [DLW-1:0] mc_s6 [2][4];
	logic                  aneg_s6, inv_s6;
	// Stage 7: A^2 and M2*C^2
	logic [SQW-1:0] a2_s7, mc_s7;
	logic           aneg_s7, inv_s7;
	// Stage 8: start of the digit recurrence
	hct_pkg::hct_root_t r_s8;
	hct_pkg::hct_root_t root_s [STEPS];
	// Output
	logic signed [COSW-1:0] cos_theta_q;
	logic                   invalid_q;

	logic [PW-1:0]  p2_sum;
	logic [PW:0]    m2_diff;
	logic [CW-1:0]  c2_sum;
	logic [SQW-1:0] a2_sum, mc_sum;
	logic [SW-1:0]  s_sum;
	logic [COSW-1:0] mag;
	logic [DLW-1:0] m2x, a0, a1;
	logic signed [LW-1:0] ah;

	// A stage may load when the output is taken or when it or any stage after it is empty
	generate
		for (genvar k = 1; k <= NS; k++) begin : g_en
			assign en[k] = out_ready || !(&vld_q[NS:k]);
		end
	endgenerate

	assign in_ready  = en[1];
	assign out_valid = vld_q[NS];
	assign cos_theta = cos_theta_q;
	assign invalid   = invalid_q;

	// Advance the valid bits with the words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// Stage 1: register the muon and form the pair sums
	always_ff @(posedge clk) begin
		if (en[1]) begin
			px_s1 <= plus_px;
			py_s1 <= plus_py;
			pz_s1 <= plus_pz;
			e1_s1 <= plus_energy;
			qx_s1 <= $signed({plus_px[MW-1], plus_px}) + $signed({minus_px[MW-1], minus_px});
			qy_s1 <= $signed({plus_py[MW-1], plus_py}) + $signed({minus_py[MW-1], minus_py});
			qz_s1 <= $signed({plus_pz[MW-1], plus_pz}) + $signed({minus_pz[MW-1], minus_pz});
			qe_s1 <= {1'b0, plus_energy} + {1'b0, minus_energy};
		end
	end

	// Stage 2: component products
	always_ff @(posedge clk) begin
		if (en[2]) begin
			dx_s2 <= PW'(px_s1) * PW'(qx_s1);
			dy_s2 <= PW'(py_s1) * PW'(qy_s1);
			dz_s2 <= PW'(pz_s1) * PW'(qz_s1);
			sx_s2 <= PW'(qx_s1) * PW'(qx_s1);
			sy_s2 <= PW'(qy_s1) * PW'(qy_s1);
			sz_s2 <= PW'(qz_s1) * PW'(qz_s1);
			yz_s2 <= PW'(py_s1) * PW'(qz_s1);
			zy_s2 <= PW'(pz_s1) * PW'(qy_s1);
			zx_s2 <= PW'(pz_s1) * PW'(qx_s1);
			xz_s2 <= PW'(px_s1) * PW'(qz_s1);
			xy_s2 <= PW'(px_s1) * PW'(qy_s1);
			yx_s2 <= PW'(py_s1) * PW'(qx_s1);
			ee_s2 <= EEW'(qe_s1) * EEW'(qe_s1);
			e1_s2 <= e1_s1;
			qe_s2 <= qe_s1;
		end
	end

	// Stage 3: sums, mass check and cross product
	always_comb begin
		p2_sum  = $unsigned(sx_s2) + $unsigned(sy_s2) + $unsigned(sz_s2);
		m2_diff = (PW+1)'(ee_s2) - (PW+1)'(p2_sum);
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			dot_s3   <= dx_s2 + dy_s2 + dz_s2;
			p2_s3    <= p2_sum;
			m2_s3    <= m2_diff[EEW-1:0];
			inv_s3   <= (PW'(ee_s2) <= p2_sum);
			cr_s3[0] <= yz_s2 - zy_s2;
			cr_s3[1] <= zx_s2 - xz_s2;
			cr_s3[2] <= xy_s2 - yx_s2;
			e1_s3    <= e1_s2;
			qe_s3    <= qe_s2;
		end
	end

	// Stage 4: split into limbs, low limb unsigned and high limb signed
	always_ff @(posedge clk) begin
		if (en[4]) begin
			qd0_s4 <= (MW+LW)'(qe_s3) * (MW+LW)'(dot_s3[LW-1:0]);
			qd1_s4 <= QDW'($signed({1'b0, qe_s3})) * QDW'($signed(dot_s3[PW-1:LW]));
			pe0_s4 <= PEW'(p2_s3[LW-1:0]) * PEW'(e1_s3);
			pe1_s4 <= PEW'(p2_s3[PW-1:LW]) * PEW'(e1_s3);
			for (int i = 0; i < 3; i++) begin
				xll_s4[i] <= DLW'(cr_s3[i][LW-1:0]) * DLW'(cr_s3[i][LW-1:0]);
				xlh_s4[i] <= (DLW+1)'($signed(cr_s3[i][PW-1:LW]))
				           * (DLW+1)'($signed({1'b0, cr_s3[i][LW-1:0]}));
				xhh_s4[i] <= DLW'($signed(cr_s3[i][PW-1:LW]))
				           * DLW'($signed(cr_s3[i][PW-1:LW]));
			end
			m2_s4  <= m2_s3;
			inv_s4 <= inv_s3;
		end
	end

	// Stage 5: recombine into A and |C|^2
	always_comb begin
		c2_sum = '0;
		for (int i = 0; i < 3; i++) begin
			c2_sum = c2_sum + (CW'(xhh_s4[i]) << DLW) + (CW'(xlh_s4[i]) << (LW + 1))
			       + CW'(xll_s4[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			a_s5   <= (AW'(qd1_s4) << LW) + AW'(qd0_s4) - (AW'(pe1_s4) << LW) - AW'(pe0_s4);
			c2_s5  <= c2_sum;
			m2_s5  <= m2_s4;
			inv_s5 <= inv_s4;
		end
	end

	// Stage 6: limb products of A*A and M2*|C|^2
	always_comb begin
		m2x = DLW'(m2_s5);
		a0  = DLW'(a_s5[LW-1:0]);
		a1  = DLW'(a_s5[DLW-1:LW]);
		ah  = $signed(a_s5[AW-1:DLW]);
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			aa00_s6 <= a0 * a0;
			aa01_s6 <= a0 * a1;
			aa11_s6 <= a1 * a1;
			aa02_s6 <= (DLW+1)'(ah) * (DLW+1)'($signed({1'b0, a0[LW-1:0]}));
			aa12_s6 <= (DLW+1)'(ah) * (DLW+1)'($signed({1'b0, a1[LW-1:0]}));
			aa22_s6 <= DLW'(ah) * DLW'(ah);
			for (int i = 0; i < 2; i++) begin
				for (int j = 0; j < 4; j++) begin
					mc_s6[i][j] <= DLW'(m2x[i*LW +: LW]) * DLW'(c2_s5[j*LW +: LW]);
				end
			end
			aneg_s6 <= a_s5[AW-1];
			inv_s6  <= inv_s5;
		end
	end

	// Stage 7: sum the partial products
	always_comb begin
		a2_sum = SQW'(aa00_s6) + (SQW'(aa01_s6) << (LW + 1)) + (SQW'(aa11_s6) << DLW)
		       + (SQW'(aa02_s6) << (DLW + 1)) + (SQW'(aa12_s6) << (3 * LW + 1))
		       + (SQW'(aa22_s6) << (2 * DLW));
		mc_sum = '0;
		for (int i = 0; i < 2; i++) begin
			for (int j = 0; j < 4; j++) begin
				mc_sum = mc_sum + (SQW'(mc_s6[i][j]) << ((i + j) * LW));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[7]) begin
			a2_s7   <= a2_sum;
			mc_s7   <= mc_sum;
			aneg_s7 <= aneg_s6;
			inv_s7  <= inv_s6;
		end
	end

	// Stage 8: seed the recurrence with u = -1 at the top bit
	assign s_sum = SW'(a2_s7) + SW'(mc_s7);

	always_ff @(posedge clk) begin
		if (en[PRE]) begin
			r_s8.res     <= (RW'(a2_s7) << (2 * F + 2)) - RW'(s_sum);
			r_s8.vsh     <= RW'(0) - (RW'(s_sum) << (F + 2));
			r_s8.d       <= RW'(s_sum) << (2 * F + 2);
			r_s8.c       <= '0;
			r_s8.invalid <= inv_s7;
			r_s8.szero   <= (s_sum == '0);
			r_s8.aneg    <= aneg_s7;
		end
	end

	// Digit recurrence, one cosine bit per stage
	generate
		for (genvar k = 0; k < STEPS; k++) begin : g_root
			if (k == 0) begin : g_first
				hct_root_step u_step (
					.clk    (clk),
					.en     (en[PRE+1+k]),
					.cur    (r_s8),
					.step_s (root_s[k])
				);
			end else begin : g_next
				hct_root_step u_step (
					.clk    (clk),
					.en     (en[PRE+1+k]),
					.cur    (root_s[k-1]),
					.step_s (root_s[k])
				);
			end
		end
	endgenerate

	// Output: apply the sign, zero the cosine of degenerate pairs
	assign mag = {1'b0, root_s[STEPS-1].c};

	always_ff @(posedge clk) begin
		if (en[NS]) begin
			if (root_s[STEPS-1].invalid || root_s[STEPS-1].szero) begin
				cos_theta_q <= '0;
			end else if (root_s[STEPS-1].aneg) begin
				cos_theta_q <= $signed(COSW'(0) - mag);
			end else begin
				cos_theta_q <= $signed(mag);
			end
			invalid_q <= root_s[STEPS-1].invalid;
		end
	end

	// Checks
	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && invalid |-> cos_theta == '0)
		else $error("invalid pair with non-zero cosine");

	a_cos_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cos_theta <= hct_pkg::COS_ONE) && (cos_theta >= -hct_pkg::COS_ONE))
		else $error("cosine out of range");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_q[1])
		else $error("accepted word not held in first stage");

endmodule

`default_nettype wire

// ===== rtl/hct_root_step.sv =====
// One stage of the restoring square-root-style search for the cosine
// magnitude: trial subtract, keep or restore, realign. Uses hct_pkg.
`default_nettype none

module hct_root_step (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire hct_pkg::hct_root_t cur,
	output hct_pkg::hct_root_t     step_s
);

	logic [hct_pkg::RW-1:0] trial;
	logic                   acc;
	hct_pkg::hct_root_t     nxt;

	// Try the next bit: accept when the residual stays non-negative
	always_comb begin
		trial   = cur.res - cur.vsh - cur.d;
		acc     = !trial[hct_pkg::RW-1];
		nxt     = cur;
		nxt.res = acc ? trial : cur.res;
		nxt.vsh = acc ? hct_pkg::RW'($signed(cur.vsh) >>> 1) + cur.d
		              : hct_pkg::RW'($signed(cur.vsh) >>> 1);
		nxt.d   = cur.d >> 2;
		nxt.c   = {cur.c[hct_pkg::STEPS-2:0], acc};
	end

	// Advance the word when the stage may move
	always_ff @(posedge clk) begin
		if (en) begin
			step_s <= nxt;
		end
	end

endmodule

`default_nettype wire
